FILE: rtl/rdcc_pkg.sv
// rdcc_pkg: widths, timing constants, state encodings and lookup tables
// for the refrigerator duty-cycle controller. No dependencies.

package rdcc_pkg;

   localparam int KNOB_W            = 12;
   localparam int WINDOW_LEN        = 16;   // power of two: average is a shift
   localparam int SUM_W             = KNOB_W + $clog2(WINDOW_LEN);
   localparam int TICKS_PER_SECOND  = 1000;
   localparam int PRESCALE_W        = 10;
   localparam int SAMPLE_EVERY_TICKS = 10;
   localparam int SAMPLE_CNT_W      = 4;
   localparam int SECOND_W          = 6;
   localparam int SECONDS_PER_MIN   = 60;
   localparam int MINUTE_W          = 12;
   localparam int DUTY_W            = 8;
   localparam int DECIDE_W          = 4;
   localparam int DECIDE_SECONDS    = 10;
   localparam int DOOR_W            = 8;
   localparam int BLINK_TIMER_W     = 11;
   localparam int BLINK_TICKS       = 200;
   localparam int PAUSE_TICKS       = 2000;
   localparam int RANGE_W           = 3;
   localparam int MODE_CODE_W       = 3;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] CSR_ON_TIME_LIMIT = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_STOP_TIME     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOOR_THRESH   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOOR_CEILING  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_PERIOD   = 3'd4;

   localparam logic [RANGE_W-1:0] RANGE_NEVER  = 3'd0;
   localparam logic [RANGE_W-1:0] RANGE_ALWAYS = 3'd6;

   localparam logic [MODE_CODE_W-1:0] CODE_NORMAL    = 3'd0;
   localparam logic [MODE_CODE_W-1:0] CODE_GO_STOP   = 3'd1;
   localparam logic [MODE_CODE_W-1:0] CODE_STOPPED   = 3'd2;
   localparam logic [MODE_CODE_W-1:0] CODE_TO_NEVER  = 3'd3;
   localparam logic [MODE_CODE_W-1:0] CODE_NEVER     = 3'd4;
   localparam logic [MODE_CODE_W-1:0] CODE_TO_ALWAYS = 3'd5;
   localparam logic [MODE_CODE_W-1:0] CODE_ALWAYS    = 3'd6;

   typedef enum logic [6:0] {
      MODE_NORMAL    = 7'b0000001,
      MODE_GO_STOP   = 7'b0000010,
      MODE_STOPPED   = 7'b0000100,
      MODE_TO_NEVER  = 7'b0001000,
      MODE_NEVER     = 7'b0010000,
      MODE_TO_ALWAYS = 7'b0100000,
      MODE_ALWAYS    = 7'b1000000
   } mode_type;

   typedef enum logic [3:0] {
      BLINK_START    = 4'b0001,
      BLINK_WAIT_OFF = 4'b0010,
      BLINK_WAIT_ON  = 4'b0100,
      BLINK_PAUSE    = 4'b1000
   } blink_type;

   function automatic logic [MODE_CODE_W-1:0] mode_code(input mode_type m);
      logic [MODE_CODE_W-1:0] c;
      case (m)
         MODE_NORMAL:    c = CODE_NORMAL;
         MODE_GO_STOP:   c = CODE_GO_STOP;
         MODE_STOPPED:   c = CODE_STOPPED;
         MODE_TO_NEVER:  c = CODE_TO_NEVER;
         MODE_NEVER:     c = CODE_NEVER;
         MODE_TO_ALWAYS: c = CODE_TO_ALWAYS;
         MODE_ALWAYS:    c = CODE_ALWAYS;
         default:        c = CODE_NORMAL;
      endcase
      return c;
   endfunction

   // knob average to setting range
   function automatic logic [RANGE_W-1:0] range_of(input logic [KNOB_W-1:0] avg);
      logic [RANGE_W-1:0] r;
      if (avg > 12'd3510)      r = 3'd6;
      else if (avg > 12'd2925) r = 3'd5;
      else if (avg > 12'd2340) r = 3'd4;
      else if (avg > 12'd1755) r = 3'd3;
      else if (avg > 12'd1170) r = 3'd2;
      else if (avg > 12'd585)  r = 3'd1;
      else                     r = 3'd0;
      return r;
   endfunction

   // on-minutes per duty period for each range
   function automatic logic [DUTY_W-1:0] duty_limit(input logic [RANGE_W-1:0] r);
      logic [DUTY_W-1:0] d;
      case (r)
         3'd1:    d = 8'd71;
         3'd2:    d = 8'd77;
         3'd3:    d = 8'd88;
         3'd4:    d = 8'd93;
         3'd5:    d = 8'd104;
         3'd6:    d = 8'd110;
         default: d = 8'd0;
      endcase
      return d;
   endfunction

endpackage

FILE: rtl/refrigerator_duty_cycle_controller.sv
// refrigerator_duty_cycle_controller: top level, one millisecond tick per transfer.
// Knob window, timers, mode and LED machines, door debounce. Uses rdcc_pkg.
//
//   channel | ports                           | direction | transfer when
//   req     | req_valid/ready, knob, door pin | in        | req_valid & req_ready
//   rsp     | rsp_valid/ready, six fields     | out       | rsp_valid & rsp_ready
//   csr     | csr_write_en, index, wdata      | in        | csr_write_en
//
// One tick per clock while req_ready is high; the result is registered and appears in the cycle after its transfer.
// The whole tick update is one combinational pass between the state registers.
// A stalled result holds req_ready low; the result register frees in the same
// cycle it is taken. Reset is synchronous and restores the register defaults.

module refrigerator_duty_cycle_controller (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [rdcc_pkg::KNOB_W-1:0]          req_knob_sample,
   input  logic                                 req_door_pin,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_relay_drive,
   output logic                                 rsp_lamp_drive,
   output logic                                 rsp_led_on,
   output logic [rdcc_pkg::RANGE_W-1:0]         rsp_setting_range,
   output logic [rdcc_pkg::MODE_CODE_W-1:0]     rsp_control_mode,
   output logic [rdcc_pkg::KNOB_W-1:0]          rsp_knob_average,
   input  logic                                 csr_write_en,
   input  logic [rdcc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [rdcc_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rdcc_pkg::*;

   localparam logic [PRESCALE_W-1:0]   PRESCALE_RELOAD = PRESCALE_W'(TICKS_PER_SECOND - 1);
   localparam logic [SAMPLE_CNT_W-1:0] SAMPLE_RELOAD   = SAMPLE_CNT_W'(SAMPLE_EVERY_TICKS);
   localparam logic [SECOND_W-1:0]     LAST_SECOND     = SECOND_W'(SECONDS_PER_MIN - 1);
   localparam logic [DECIDE_W-1:0]     DECIDE_RELOAD   = DECIDE_W'(DECIDE_SECONDS);
   localparam logic [BLINK_TIMER_W-1:0] BLINK_RELOAD   = BLINK_TIMER_W'(BLINK_TICKS);
   localparam logic [BLINK_TIMER_W-1:0] PAUSE_RELOAD   = BLINK_TIMER_W'(PAUSE_TICKS);

   // configuration
   logic [MINUTE_W-1:0] on_limit_ff;
   logic [MINUTE_W-1:0] stop_time_ff;
   logic [DOOR_W-1:0]   door_thresh_ff;
   logic [DOOR_W-1:0]   door_ceiling_ff;
   logic [DUTY_W-1:0]   duty_period_ff;

   // tick state
   logic [KNOB_W-1:0]        window_ff [WINDOW_LEN];
   logic [KNOB_W-1:0]        window_in [WINDOW_LEN];
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [SAMPLE_CNT_W-1:0]  sample_cnt_ff, sample_cnt_in;
   logic [RANGE_W-1:0]       range_ff, range_in;
   logic [PRESCALE_W-1:0]    prescale_ff, prescale_in;
   logic [SECOND_W-1:0]      second_ff, second_in;
   logic [MINUTE_W-1:0]      minute_ff, minute_in;
   logic [DUTY_W-1:0]        duty_ff, duty_in;
   logic [DECIDE_W-1:0]      decide_ff, decide_in;
   mode_type                 mode_ff, mode_in;
   logic                     relay_ff, relay_in;
   logic [DOOR_W-1:0]        door_ff, door_in;
   blink_type                blink_ff, blink_in;
   logic [RANGE_W-1:0]       blinks_left_ff, blinks_left_in;
   logic [BLINK_TIMER_W-1:0] blink_timer_ff, blink_timer_in;
   logic                     led_ff, led_in;
   logic                     light_ff, light_in;
   logic                     rsp_valid_ff;

   logic second_tick;
   logic minute_tick;
   logic take_sample;
   logic req_fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      // door debounce
      door_in = door_ff;
      if (req_door_pin) begin
         if (door_ff < door_ceiling_ff) door_in = door_ff + 8'd1;
      end else if (door_ff != '0) begin
         door_in = door_ff - 8'd1;
      end
      light_in = (door_in >= door_thresh_ff);

      // timebase
      second_tick = (prescale_ff == '0);
      prescale_in = second_tick ? PRESCALE_RELOAD : prescale_ff - 1'b1;
      minute_tick = second_tick && (second_ff >= LAST_SECOND);
      decide_in   = decide_ff;
      second_in   = second_ff;
      minute_in   = minute_ff;
      duty_in     = duty_ff;
      if (second_tick) begin
         if (decide_ff != '0) decide_in = decide_ff - 1'b1;
         second_in = minute_tick ? '0 : second_ff + 1'b1;
      end
      if (minute_tick) begin
         if (minute_ff != '1) minute_in = minute_ff + 1'b1;
         if (duty_ff != '1)   duty_in   = duty_ff + 1'b1;
      end

      // knob sampling
      sample_cnt_in = (sample_cnt_ff != '0) ? sample_cnt_ff - 1'b1 : sample_cnt_ff;
      take_sample   = (sample_cnt_in == '0);
      window_in     = window_ff;
      sum_in        = sum_ff;
      range_in      = range_ff;
      if (take_sample) begin
         sample_cnt_in = SAMPLE_RELOAD;
         for (int i = 0; i < WINDOW_LEN - 1; i++) window_in[i] = window_ff[i+1];
         window_in[WINDOW_LEN-1] = req_knob_sample;
         sum_in   = sum_ff - SUM_W'(window_ff[0]) + SUM_W'(req_knob_sample);
         range_in = range_of(KNOB_W'(sum_in / WINDOW_LEN));
      end

      // mode machine
      mode_in  = mode_ff;
      relay_in = relay_ff;
      case (mode_ff)
         MODE_NORMAL: begin
            if (decide_in == '0) begin
               decide_in = DECIDE_RELOAD;
               if (range_in != RANGE_NEVER && range_in != RANGE_ALWAYS) begin
                  relay_in = (duty_in < duty_limit(range_in));
                  if (duty_in >= duty_period_ff) duty_in = '0;
               end
            end
            if (minute_in >= on_limit_ff)   mode_in = MODE_GO_STOP;
            if (range_in == RANGE_NEVER)    mode_in = MODE_TO_NEVER;
            if (range_in == RANGE_ALWAYS)   mode_in = MODE_TO_ALWAYS;
         end
         MODE_GO_STOP: begin
            minute_in = '0;
            relay_in  = 1'b0;
            mode_in   = MODE_STOPPED;
         end
         MODE_STOPPED: begin
            if (minute_in >= stop_time_ff) begin
               mode_in   = MODE_NORMAL;
               minute_in = '0;
               duty_in   = '0;
            end
         end
         MODE_TO_NEVER: begin
            relay_in = 1'b0;
            mode_in  = MODE_NEVER;
         end
         MODE_NEVER: begin
            if (range_in != RANGE_NEVER) begin
               mode_in   = MODE_NORMAL;
               minute_in = '0;
               duty_in   = '0;
            end
         end
         MODE_TO_ALWAYS: begin
            relay_in = 1'b1;
            mode_in  = MODE_ALWAYS;
         end
         MODE_ALWAYS: begin
            if (range_in != RANGE_ALWAYS) mode_in = MODE_NORMAL;
            if (minute_in >= on_limit_ff) mode_in = MODE_GO_STOP;
         end
         default: mode_in = MODE_NORMAL;
      endcase

      // LED blinks the range number
      blink_timer_in = (blink_timer_ff != '0) ? blink_timer_ff - 1'b1 : blink_timer_ff;
      blink_in       = blink_ff;
      blinks_left_in = blinks_left_ff;
      led_in         = led_ff;
      case (blink_ff)
         BLINK_START: begin
            blinks_left_in = range_in;
            if (range_in != '0) begin
               led_in         = 1'b1;
               blink_timer_in = BLINK_RELOAD;
               blink_in       = BLINK_WAIT_OFF;
               blinks_left_in = range_in - 1'b1;
            end
         end
         BLINK_WAIT_OFF: begin
            if (blink_timer_in == '0) begin
               led_in         = 1'b0;
               blink_timer_in = BLINK_RELOAD;
               blink_in       = BLINK_WAIT_ON;
            end
         end
         BLINK_WAIT_ON: begin
            if (blink_timer_in == '0) begin
               if (blinks_left_ff != '0) begin
                  blinks_left_in = blinks_left_ff - 1'b1;
                  blink_timer_in = BLINK_RELOAD;
                  blink_in       = BLINK_WAIT_OFF;
                  led_in         = 1'b1;
               end else begin
                  blink_in       = BLINK_PAUSE;
                  blink_timer_in = PAUSE_RELOAD;
               end
            end
         end
         default: begin
            if (blink_timer_in == '0) blink_in = BLINK_START;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         on_limit_ff     <= 12'd360;
         stop_time_ff    <= 12'd25;
         door_thresh_ff  <= 8'd100;
         door_ceiling_ff <= 8'd200;
         duty_period_ff  <= 8'd110;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_ON_TIME_LIMIT: on_limit_ff     <= csr_wdata[MINUTE_W-1:0];
            CSR_STOP_TIME:     stop_time_ff    <= csr_wdata[MINUTE_W-1:0];
            CSR_DOOR_THRESH:   door_thresh_ff  <= csr_wdata[DOOR_W-1:0];
            CSR_DOOR_CEILING:  door_ceiling_ff <= csr_wdata[DOOR_W-1:0];
            CSR_DUTY_PERIOD:   duty_period_ff  <= csr_wdata[DUTY_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WINDOW_LEN; i++) window_ff[i] <= '0;
         sum_ff         <= '0;
         sample_cnt_ff  <= '0;
         range_ff       <= '0;
         prescale_ff    <= '0;
         second_ff      <= '0;
         minute_ff      <= '0;
         duty_ff        <= '0;
         decide_ff      <= '0;
         mode_ff        <= MODE_NORMAL;
         relay_ff       <= 1'b0;
         door_ff        <= '0;
         blink_ff       <= BLINK_START;
         blinks_left_ff <= '0;
         blink_timer_ff <= '0;
         led_ff         <= 1'b0;
         light_ff       <= 1'b0;
      end else if (req_fire) begin
         window_ff      <= window_in;
         sum_ff         <= sum_in;
         sample_cnt_ff  <= sample_cnt_in;
         range_ff       <= range_in;
         prescale_ff    <= prescale_in;
         second_ff      <= second_in;
         minute_ff      <= minute_in;
         duty_ff        <= duty_in;
         decide_ff      <= decide_in;
         mode_ff        <= mode_in;
         relay_ff       <= relay_in;
         door_ff        <= door_in;
         blink_ff       <= blink_in;
         blinks_left_ff <= blinks_left_in;
         blink_timer_ff <= blink_timer_in;
         led_ff         <= led_in;
         light_ff       <= light_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // state only moves on a transfer, so it still matches a held result
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_relay_drive   = relay_ff;
   assign rsp_lamp_drive    = light_ff;
   assign rsp_led_on        = led_ff;
   assign rsp_setting_range = range_ff;
   assign rsp_control_mode  = mode_code(mode_ff);
   assign rsp_knob_average  = KNOB_W'(sum_ff / WINDOW_LEN);

endmodule
